/* src/ism_pkg.sv */
// Shared types and constants for the interval set merge table.
// No dependencies; imported by ism_ctrl, the top level and the checker.
package ism_pkg;

	localparam int MAX_RANGES = 16;
	localparam int KEY_BITS   = 16;
	localparam int IDX_W      = $clog2(MAX_RANGES);
	localparam int CNT_W      = $clog2(MAX_RANGES + 1);
	localparam int NC_W       = CNT_W + 1;
	localparam int ENTRY_W    = 2 * KEY_BITS;

	localparam logic OP_QUERY  = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [IDX_W-1:0]    idx_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_ORDER = 2'd2
	} status_t;

	typedef struct packed {
		key_t lo;
		key_t hi;
	} entry_t;

	typedef struct packed {
		logic    covered;
		status_t status;
		cnt_t    range_count;
	} result_t;

endpackage

/* src/ism_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
module ism_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* src/ism_ctrl.sv */
// Sequencer for the interval set merge table: scans, merges and moves entries.
// Depends on ism_pkg; drives the range RAM through its read and write ports.
module ism_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  operation,
	input  ism_pkg::key_t         query_key,
	input  ism_pkg::key_t         range_start,
	input  ism_pkg::key_t         range_end,
	output logic                  res_valid,
	output ism_pkg::result_t      res,
	input  logic                  res_take,
	output logic                  rd_en,
	output ism_pkg::idx_t         rd_addr,
	input  ism_pkg::entry_t       rd_data,
	output logic                  wr_en,
	output ism_pkg::idx_t         wr_addr,
	output ism_pkg::entry_t       wr_data
);
	import ism_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_MOVE,
		S_RESULT
	} state_t;

	state_t  state_q;
	cnt_t    count_q;
	logic    ins_q;
	key_t    s_q;
	key_t    e_q;
	cnt_t    idx_q;
	cnt_t    first_q;
	logic    found_q;
	cnt_t    rd_ptr_q;
	cnt_t    wr_ptr_q;
	cnt_t    mv_left_q;
	logic    up_q;
	logic    wnew_q;
	logic    cov_q;
	status_t stat_q;
	cnt_t    rcnt_q;
	logic    wv_s1;
	idx_t    wa_s1;

	// scan evaluation
	logic     at_end;
	logic     scan_done;
	logic     scan_adv;
	logic     scan_merge;
	logic     scan_found;
	logic     q_cov;
	cnt_t     first_f;
	cnt_t     last_f;
	cnt_t     idx_nx;
	logic [NC_W-1:0] newcnt;
	cnt_t     merged;
	logic     move_end;

	assign at_end = (idx_q >= count_q);
	assign idx_nx = idx_q + cnt_t'(1);

	always_comb begin
		scan_done  = 1'b0;
		scan_adv   = 1'b0;
		scan_merge = 1'b0;
		scan_found = 1'b0;
		q_cov      = 1'b0;
		first_f    = first_q;
		last_f     = idx_q;
		if (!ins_q) begin
			if (at_end) begin
				scan_done = 1'b1;
			end else if (rd_data.hi >= s_q) begin
				scan_done = 1'b1;
				q_cov     = (s_q >= rd_data.lo);
			end else begin
				scan_adv = 1'b1;
			end
		end else begin
			if (at_end) begin
				scan_done = 1'b1;
				first_f   = found_q ? first_q : idx_q;
			end else if (!found_q) begin
				if (rd_data.hi < s_q) begin
					scan_adv = 1'b1;
				end else if (rd_data.lo <= e_q) begin
					scan_adv   = 1'b1;
					scan_merge = 1'b1;
					scan_found = 1'b1;
				end else begin
					scan_done = 1'b1;
					first_f   = idx_q;
				end
			end else begin
				if (rd_data.lo <= e_q) begin
					scan_adv   = 1'b1;
					scan_merge = 1'b1;
				end else begin
					scan_done = 1'b1;
				end
			end
		end
	end

	assign merged = last_f - first_f;
	assign newcnt = {1'b0, count_q} - {1'b0, merged} + NC_W'(1);
	assign move_end = (mv_left_q == '0) && !wv_s1;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		case (state_q)
			S_IDLE: begin
				rd_en   = in_valid;
				rd_addr = '0;
			end
			S_SCAN: begin
				rd_en   = scan_adv;
				rd_addr = idx_nx[IDX_W-1:0];
			end
			S_MOVE: begin
				rd_en   = (mv_left_q != '0);
				rd_addr = rd_ptr_q[IDX_W-1:0];
			end
			default: begin
				rd_en   = 1'b0;
				rd_addr = '0;
			end
		endcase
	end

	always_comb begin
		if (state_q == S_MOVE) begin
			wr_en   = wv_s1;
			wr_addr = wa_s1;
			wr_data = rd_data;
		end else begin
			wr_en   = (state_q == S_RESULT) && wnew_q && res_take;
			wr_addr = first_q[IDX_W-1:0];
			wr_data = '{lo: s_q, hi: e_q};
		end
	end

	assign in_ready          = (state_q == S_IDLE);
	assign res_valid         = (state_q == S_RESULT);
	assign res.covered       = cov_q;
	assign res.status        = stat_q;
	assign res.range_count   = rcnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			wv_s1   <= 1'b0;
			wnew_q  <= 1'b0;
		end else begin
			// write back the entry read in the previous move cycle
			wv_s1 <= (state_q == S_MOVE) && (mv_left_q != '0);
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						ins_q   <= (operation == OP_INSERT);
						idx_q   <= '0;
						found_q <= 1'b0;
						first_q <= '0;
						cov_q   <= 1'b0;
						stat_q  <= (operation == OP_INSERT && range_start > range_end) ?
							ST_ORDER : ST_OK;
						rcnt_q  <= count_q;
						wnew_q  <= 1'b0;
						if (operation == OP_INSERT) begin
							s_q <= range_start;
							e_q <= range_end;
							if (range_start > range_end) begin
								state_q <= S_RESULT;
							end else begin
								state_q <= S_SCAN;
							end
						end else begin
							s_q     <= query_key;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_merge) begin
						if (rd_data.lo < s_q) begin
							s_q <= rd_data.lo;
						end
						if (rd_data.hi > e_q) begin
							e_q <= rd_data.hi;
						end
					end
					if (scan_found) begin
						found_q <= 1'b1;
						first_q <= idx_q;
					end
					if (scan_adv) begin
						idx_q <= idx_nx;
					end
					if (scan_done) begin
						first_q <= first_f;
						if (!ins_q) begin
							cov_q   <= q_cov;
							state_q <= S_RESULT;
						end else if (newcnt > NC_W'(MAX_RANGES)) begin
							stat_q  <= ST_FULL;
							state_q <= S_RESULT;
						end else begin
							rcnt_q    <= newcnt[CNT_W-1:0];
							mv_left_q <= count_q - last_f;
							up_q      <= (merged != '0);
							if (merged == '0) begin
								// open a slot: copy the tail upward, top entry first
								rd_ptr_q <= count_q - cnt_t'(1);
								wr_ptr_q <= count_q;
							end else begin
								// close the gap: copy the tail downward, lowest first
								rd_ptr_q <= last_f;
								wr_ptr_q <= first_f + cnt_t'(1);
							end
							state_q <= S_MOVE;
						end
					end
				end
				S_MOVE: begin
					if (mv_left_q != '0) begin
						mv_left_q <= mv_left_q - cnt_t'(1);
						wa_s1     <= wr_ptr_q[IDX_W-1:0];
						if (up_q) begin
							rd_ptr_q <= rd_ptr_q + cnt_t'(1);
							wr_ptr_q <= wr_ptr_q + cnt_t'(1);
						end else begin
							rd_ptr_q <= rd_ptr_q - cnt_t'(1);
							wr_ptr_q <= wr_ptr_q - cnt_t'(1);
						end
					end
					if (move_end) begin
						wnew_q  <= 1'b1;
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (res_take) begin
						count_q <= rcnt_q;
						wnew_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* src/interval_set_merge_table_top.sv */
// Interval set merge table: one item in, one result out per transfer.
// A query scans the ranges in order until one ends at or above the key; an
// insert scans, merges the ranges it overlaps and moves the table tail, with
// one RAM read and one write per cycle. A new item is taken in the cycle after
// the result is passed to the output register. Reset empties the table.
module interval_set_merge_table_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          operation,
	input  ism_pkg::key_t query_key,
	input  ism_pkg::key_t range_start,
	input  ism_pkg::key_t range_end,
	output logic          out_valid,
	input  logic          out_stall,
	output logic          covered,
	output logic [1:0]    status,
	output ism_pkg::cnt_t range_count
);
	import ism_pkg::*;

	logic    in_ready;
	logic    res_valid;
	result_t res;
	logic    res_take;
	logic    rd_en;
	idx_t    rd_addr;
	entry_t  rd_data;
	logic    wr_en;
	idx_t    wr_addr;
	entry_t  wr_data;
	logic    out_valid_q;
	result_t out_q;

	assign in_stall = !in_ready;
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	ism_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.query_key   (query_key),
		.range_start (range_start),
		.range_end   (range_end),
		.res_valid   (res_valid),
		.res         (res),
		.res_take    (res_take),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data)
	);

	ism_ram #(
		.DEPTH (MAX_RANGES),
		.WIDTH (ENTRY_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// output register: hold until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign covered     = out_q.covered;
	assign status      = out_q.status;
	assign range_count = out_q.range_count;

endmodule

/* src/ism_checker.sv */
// Port-level checks for the interval set merge table, bound to the top level.
// Depends on ism_pkg and interval_set_merge_table_top.
module ism_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_stall,
	input logic          out_valid,
	input logic          out_stall,
	input logic          covered,
	input logic [1:0]    status,
	input ism_pkg::cnt_t range_count
);
	import ism_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(covered) && $stable(status)
			&& $stable(range_count))
		else $error("stalled result changed");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> range_count <= CNT_W'(MAX_RANGES))
		else $error("range count above table size");

	a_cov_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && covered |-> status == ST_OK)
		else $error("covered set on a rejected insert");

	// one item at a time: busy right after an input transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while busy");

endmodule

bind interval_set_merge_table_top ism_checker u_ism_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.covered     (covered),
	.status      (status),
	.range_count (range_count)
);
